FILE: hw/rtl/lss_pkg.sv
// Shared types and constants for the LIFO stack with search.
package lss_pkg;

  localparam int VALUE_W   = 32;
  localparam int CNT_OUT_W = 9;
  localparam int CAP_W     = 16;
  localparam int CFG_W     = 13;
  localparam int GROUP_W   = 16;

  localparam logic [CAP_W-1:0] CAP_RESET = 16'd4;
  localparam logic [CAP_W-1:0] CAP_MAX   = 16'hFFFF;

  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_PEEK   = 2'd2,
    ACT_SEARCH = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_MATCH,
    CS_GROUP
  } ctl_state_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic cmp;
  } cell_ctl_t;

endpackage

FILE: hw/rtl/lss_if.sv
// Handshake channel interfaces: request, result and configuration write.
interface lss_req_if;
  logic                       valid;
  logic                       ready;
  lss_pkg::action_t           action;
  logic [lss_pkg::VALUE_W-1:0] value;
  modport source (output valid, action, value, input ready);
  modport sink   (input valid, action, value, output ready);
endinterface

interface lss_rsp_if;
  logic                          valid;
  logic                          ready;
  lss_pkg::status_t              status;
  logic [lss_pkg::VALUE_W-1:0]   top_value;
  logic                          found;
  logic [lss_pkg::CNT_OUT_W-1:0] count;
  logic [lss_pkg::CAP_W-1:0]     capacity;
  modport source (output valid, status, top_value, found, count, capacity, input ready);
  modport sink   (input valid, status, top_value, found, count, capacity, output ready);
endinterface

interface lss_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [lss_pkg::CFG_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: hw/rtl/lss_cell.sv
// One stack cell: a word, its occupied flag and a registered match bit.
module lss_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lss_pkg::cell_ctl_t    ctl,
  input  logic [DATA_WIDTH-1:0] key,
  input  logic [DATA_WIDTH-1:0] up_data,
  input  logic                  up_occ,
  input  logic [DATA_WIDTH-1:0] dn_data,
  input  logic                  dn_occ,
  output logic [DATA_WIDTH-1:0] data,
  output logic                  occ,
  output logic                  match
);
  import lss_pkg::*;

  logic [DATA_WIDTH-1:0] data_r, data_nxt;
  logic                  occ_r, occ_nxt;
  logic                  match_r, match_nxt;

  always_comb begin
    data_nxt  = data_r;
    occ_nxt   = occ_r;
    match_nxt = match_r;
    // push moves every word one cell deeper, pop pulls one cell up
    if (ctl.push) begin
      data_nxt = up_data;
      occ_nxt  = up_occ;
    end else if (ctl.pop) begin
      data_nxt = dn_data;
      occ_nxt  = dn_occ;
    end
    if (ctl.cmp) begin
      match_nxt = occ_r && (data_r == key);
    end
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    match_r <= match_nxt;
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  assign data  = data_r;
  assign occ   = occ_r;
  assign match = match_r;

endmodule

FILE: hw/rtl/lss_match_tree.sv
// Registered first level of the match reduction: one OR per group of cells.
module lss_match_tree #(
  parameter int NGRP = 16
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic [NGRP*lss_pkg::GROUP_W-1:0]  match,
  output logic [NGRP-1:0]                   grp
);
  import lss_pkg::*;

  logic [NGRP-1:0] grp_r, grp_nxt;

  always_comb begin
    grp_nxt = grp_r;
    if (en) begin
      for (int g = 0; g < NGRP; g++) begin
        grp_nxt[g] = |match[g*GROUP_W +: GROUP_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
  end

  assign grp = grp_r;

endmodule

FILE: hw/rtl/lifo_stack_with_search.sv
// LIFO stack with search: a row of shifting cells and its controller.
//
// Requests arrive on in_ch (action, value); each gives exactly one result on
// out_ch (status, top_value, found, count, capacity). cfg_ch writes the
// starting capacity and reloads the capacity counter; it is always ready and
// must only be used while no request is in flight.
// Cell 0 holds the top word. A push shifts the whole row one cell deeper, a
// pop shifts it one cell up, so push, pop and peek finish in the accept cycle
// and their result is registered for out_ch in the cycle after. A search runs
// in steps: every cell registers its own compare, groups of 16 match bits are
// ORed into registers, then the group bits are ORed into the result. One
// request is in flight at a time.
// A new transaction is taken while the previous result is being read out; if
// the receiver stalls, the result is held and in_ch.ready stays low until
// it is taken.
// Reset empties the stack and sets the capacity to 4; stored words are not
// cleared.
module lifo_stack_with_search #(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  lss_req_if.sink   in_ch,
  lss_rsp_if.source out_ch,
  lss_cfg_if.sink   cfg_ch
);
  import lss_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int NGRP  = (DEPTH + GROUP_W - 1) / GROUP_W;

  ctl_state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CAP_W-1:0] cap_r, cap_nxt;

  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r;
  logic [VALUE_W-1:0]   out_top_r;
  logic             out_found_r;
  logic [CNT_OUT_W-1:0] out_count_r;
  logic [CAP_W-1:0] out_cap_r;

  logic             load;
  status_t          res_status;
  logic [VALUE_W-1:0] res_top;
  logic             res_found;
  cell_ctl_t        ctl;

  logic                  in_fire, cfg_fire, full, empty, cap_hit;
  logic [DATA_WIDTH-1:0] word;
  logic [DATA_WIDTH+VALUE_W-1:0] word_ext;
  logic [VALUE_W+DATA_WIDTH-1:0] top_ext;
  logic [CNT_W+CNT_OUT_W-1:0]    cnt_ext;
  logic [CAP_W:0]                cap_dbl;
  logic [CAP_W-1:0]              cap_next_dbl;

  logic [DATA_WIDTH-1:0]   data_w [DEPTH];
  logic [DEPTH-1:0]        occ_w;
  logic [NGRP*GROUP_W-1:0] match_w;
  logic [NGRP-1:0]         grp_w;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign cfg_fire = cfg_ch.valid && cfg_ch.ready;
  assign in_ch.ready  = (state_r == CS_IDLE) && (!out_valid_r || out_ch.ready);
  assign cfg_ch.ready = 1'b1;

  assign word_ext = {{DATA_WIDTH{1'b0}}, in_ch.value};
  assign word     = word_ext[DATA_WIDTH-1:0];
  assign top_ext  = {{VALUE_W{1'b0}}, data_w[0]};

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign cap_hit = {{CAP_W{1'b0}}, count_r} >= {{CNT_W{1'b0}}, cap_r};
  assign cap_dbl = {cap_r, 1'b0};
  assign cap_next_dbl = cap_dbl[CAP_W] ? CAP_MAX : cap_dbl[CAP_W-1:0];

  // cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] up_d, dn_d;
    logic                  up_o, dn_o;
    if (i == 0) begin : g_top
      assign up_d = word;
      assign up_o = 1'b1;
    end else begin : g_mid
      assign up_d = data_w[i-1];
      assign up_o = occ_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_bot
      assign dn_d = '0;
      assign dn_o = 1'b0;
    end else begin : g_low
      assign dn_d = data_w[i+1];
      assign dn_o = occ_w[i+1];
    end
    lss_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .key     (word),
      .up_data (up_d),
      .up_occ  (up_o),
      .dn_data (dn_d),
      .dn_occ  (dn_o),
      .data    (data_w[i]),
      .occ     (occ_w[i]),
      .match   (match_w[i])
    );
  end

  if (NGRP * GROUP_W > DEPTH) begin : g_pad
    assign match_w[NGRP*GROUP_W-1:DEPTH] = '0;
  end

  lss_match_tree #(.NGRP(NGRP)) u_tree (
    .clk   (clk),
    .en    (state_r == CS_MATCH),
    .match (match_w),
    .grp   (grp_w)
  );

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    cap_nxt    = cap_r;
    ctl        = '0;
    load       = 1'b0;
    res_status = ST_OK;
    res_top    = '0;
    res_found  = 1'b0;
    unique case (state_r)
      CS_IDLE: begin
        if (in_fire) begin
          unique case (in_ch.action)
            ACT_PUSH: begin
              load = 1'b1;
              if (full) begin
                res_status = ST_FULL;
              end else begin
                ctl.push  = 1'b1;
                count_nxt = count_r + 1'b1;
                if (cap_hit) begin
                  cap_nxt = cap_next_dbl;
                end
              end
            end
            ACT_POP: begin
              load = 1'b1;
              if (empty) begin
                res_status = ST_EMPTY;
              end else begin
                ctl.pop   = 1'b1;
                count_nxt = count_r - 1'b1;
              end
            end
            ACT_PEEK: begin
              load = 1'b1;
              if (empty) begin
                res_status = ST_EMPTY;
              end else begin
                res_top = top_ext[VALUE_W-1:0];
              end
            end
            ACT_SEARCH: begin
              ctl.cmp   = 1'b1;
              state_nxt = CS_MATCH;
            end
          endcase
        end
      end
      CS_MATCH: state_nxt = CS_GROUP;
      CS_GROUP: begin
        load      = 1'b1;
        res_found = |grp_w;
        state_nxt = CS_IDLE;
      end
    endcase
  end

  assign cnt_ext = {{CNT_OUT_W{1'b0}}, count_nxt};

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status_r <= res_status;
      out_top_r    <= res_top;
      out_found_r  <= res_found;
      out_count_r  <= cnt_ext[CNT_OUT_W-1:0];
      out_cap_r    <= cap_nxt;
    end
    if (!rst_n) begin
      state_r     <= CS_IDLE;
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      // a capacity write reloads the counter
      cap_r <= cfg_fire ? {{(CAP_W-CFG_W){1'b0}}, cfg_ch.data} : cap_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.top_value = out_top_r;
  assign out_ch.found     = out_found_r;
  assign out_ch.count     = out_count_r;
  assign out_ch.capacity  = out_cap_r;

  a_top_occ: assert property (@(posedge clk) disable iff (!rst_n)
    occ_w[0] == (count_r != '0))
    else $error("top cell occupancy disagrees with count");

  a_bot_occ: assert property (@(posedge clk) disable iff (!rst_n)
    occ_w[DEPTH-1] == full)
    else $error("bottom cell occupancy disagrees with full");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!out_valid_r || out_ch.ready))
    else $error("result register overwritten while held");

  a_busy_block: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != CS_IDLE) |-> !in_ch.ready)
    else $error("request taken during search");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("count beyond depth");

endmodule
